FILE: design/tas_pkg.sv
// Shared types and codes for the traffic automaton step core.
`default_nettype none
package tas_pkg;

  // Cell contents
  typedef logic [1:0] cell_t;
  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_RED   = 2'd1;
  localparam cell_t CELL_BLUE  = 2'd2;
  localparam cell_t CELL_UNUSED = 2'd3;

  // Request codes
  typedef logic [1:0] req_t;
  localparam req_t REQ_LOAD    = 2'd0;
  localparam req_t REQ_ADVANCE = 2'd1;
  localparam req_t REQ_READ    = 2'd2;

  // Field widths fixed by the interface
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd20;

endpackage
`default_nettype wire

FILE: design/traffic_automaton_step_core.sv
// Top level of the traffic automaton step core: grid memories, sweep sequencer, handshakes.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: load a cell, read a cell
//   or advance the grid by one full step. The output channel (out_valid/out_ready)
//   returns exactly one result word per request: the cell read (0 otherwise) and a
//   bad_request flag for a load or read whose row or column is not below the side.
//   cfg_wr_en/cfg_wr_data write the grid side length; write it only while idle.
// Sequence: a load, an unknown request or a flagged read goes straight to the finish
//   state; a good read passes the read wait state first; an advance runs the red and
//   then the blue sweep, each followed by a drain state. The red half-step sweeps rows and
//   the blue half-step sweeps columns, one memory read per cycle, n+2 reads per line for
//   side n (both wrap neighbors are re-read at the line ends).
// Throughput: one request at a time; the next word is taken while the previous
//   result waits in the output register.
// Reset: the side length returns to 20 and the control clears; grid contents stay
//   undefined until loaded. No clearing pass is run.
// Stall: when the receiver holds out_ready low, a finished result waits in the
//   output register and a second finished result waits inside; no input is taken
//   until the output slot drains.
`default_nettype none
module traffic_automaton_step_core #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [tas_pkg::SIZE_W-1:0] cfg_wr_data,
  // request channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire tas_pkg::req_t          in_req_type,
  input  wire logic [tas_pkg::COORD_W-1:0] in_row,
  input  wire logic [tas_pkg::COORD_W-1:0] in_col,
  input  wire tas_pkg::cell_t         in_cell_in,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tas_pkg::cell_t              out_cell_out,
  output logic                        out_bad_request
);
  import tas_pkg::*;

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int NW     = $clog2(MAX_SIDE + 1);
  localparam int PW     = $clog2(MAX_SIDE + 2);
  localparam int AW     = 2 * SIDE_W;
  localparam int DEPTH  = 1 << AW;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Grid memories
  cell_t cell_mem [DEPTH];
  cell_t scr_mem  [DEPTH];

  logic [SIZE_W-1:0] grid_size_r;
  logic [2:0]        state_r, state_nxt;
  logic              pass_r, pass_nxt;     // 0 red half-step, 1 blue half-step
  logic [SIDE_W-1:0] line_r, line_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [SIDE_W-1:0] line_d_r;
  logic [PW-1:0]     pos_d_r;
  logic              rd_v_r;
  cell_t             w_prev_r, w_cur_r;
  cell_t             res_cell_r, res_cell_nxt;
  logic              res_bad_r, res_bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  cell_t             out_cell_r;
  logic              out_bad_r;

  logic [NW-1:0]     side;
  logic [PW-1:0]     side_p1;
  logic [SIDE_W-1:0] idx;
  logic [SIDE_W-1:0] center;
  logic [AW-1:0]     sweep_addr, req_addr, rd_addr, wr_addr;
  cell_t             cell_rdata, scr_rdata, src_data;
  cell_t             kind, fwd_cell, back_cell, new_cell, load_val;
  logic              in_acc, bad_coord, sweep_wr, line_end, last_line, out_free;
  logic              cell_we, scr_we;
  cell_t             cell_wdata;

  // Clamp the configured side into the supported range
  always_comb begin
    if (grid_size_r == '0) begin
      side = NW'(1);
    end else if (int'(grid_size_r) > MAX_SIDE) begin
      side = NW'(MAX_SIDE);
    end else begin
      side = NW'(grid_size_r);
    end
  end

  assign side_p1   = PW'(side) + PW'(1);
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign bad_coord = (int'(in_row) >= int'(side)) || (int'(in_col) >= int'(side));
  assign load_val  = (in_cell_in == CELL_UNUSED) ? CELL_EMPTY : in_cell_in;

  // Sweep read index: wrap neighbor first, then the line, then the other wrap neighbor
  always_comb begin
    if (pos_r == '0) begin
      idx = SIDE_W'(side - NW'(1));
    end else if (pos_r == side_p1) begin
      idx = '0;
    end else begin
      idx = SIDE_W'(pos_r - PW'(1));
    end
  end

  assign line_end   = (pos_r == side_p1);
  assign last_line  = (NW'(line_r) == side - NW'(1));
  assign sweep_addr = pass_r ? {idx, line_r} : {line_r, idx};
  assign req_addr   = {SIDE_W'(in_row), SIDE_W'(in_col)};
  assign rd_addr    = (state_r == S_IDLE) ? req_addr : sweep_addr;

  // Update the center cell from its window
  assign center    = SIDE_W'(pos_d_r - PW'(2));
  assign src_data  = pass_r ? scr_rdata : cell_rdata;
  assign kind      = pass_r ? CELL_BLUE : CELL_RED;
  assign fwd_cell  = pass_r ? w_prev_r : src_data;
  assign back_cell = pass_r ? src_data : w_prev_r;
  always_comb begin
    if ((w_cur_r == kind) && (fwd_cell == CELL_EMPTY)) begin
      new_cell = CELL_EMPTY;
    end else if ((w_cur_r == CELL_EMPTY) && (back_cell == kind)) begin
      new_cell = kind;
    end else begin
      new_cell = w_cur_r;
    end
  end

  assign sweep_wr = rd_v_r && (pos_d_r >= PW'(2));
  assign wr_addr  = pass_r ? {center, line_d_r} : {line_d_r, center};

  // Select memory writes: loads and the blue pass go to the grid, the red pass to scratch
  always_comb begin
    scr_we     = sweep_wr && !pass_r;
    cell_we    = 1'b0;
    cell_wdata = new_cell;
    if (sweep_wr && pass_r) begin
      cell_we = 1'b1;
    end else if (in_acc && (in_req_type == REQ_LOAD) && !bad_coord) begin
      cell_we    = 1'b1;
      cell_wdata = load_val;
    end
  end

  // Grid memory
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_we && !(sweep_wr && pass_r) ? req_addr : wr_addr] <= cell_wdata;
    end
    cell_rdata <= cell_mem[rd_addr];
  end

  // Scratch memory
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[wr_addr] <= new_cell;
    end
    scr_rdata <= scr_mem[rd_addr];
  end

  // Sequence the requests and the sweeps
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    line_nxt      = line_r;
    pos_nxt       = pos_r;
    res_cell_nxt  = res_cell_r;
    res_bad_nxt   = res_bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_cell_nxt = CELL_EMPTY;
          res_bad_nxt  = 1'b0;
          pass_nxt     = 1'b0;
          line_nxt     = '0;
          pos_nxt      = '0;
          if (in_req_type == REQ_ADVANCE) begin
            state_nxt = S_SWEEP;
          end else if ((in_req_type == REQ_LOAD) || (in_req_type == REQ_READ)) begin
            res_bad_nxt = bad_coord;
            state_nxt   = ((in_req_type == REQ_READ) && !bad_coord) ? S_RDW : S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SWEEP: begin
        if (line_end) begin
          pos_nxt = '0;
          if (last_line) begin
            state_nxt = S_DRAIN;
          end else begin
            line_nxt = line_r + SIDE_W'(1);
          end
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end
      S_DRAIN: begin
        line_nxt = '0;
        if (pass_r) begin
          state_nxt = S_DONE;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = S_SWEEP;
        end
      end
      S_RDW: begin
        res_cell_nxt = cell_rdata;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= SIZE_RESET;
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grid_size_r <= cfg_wr_data;
      end
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      rd_v_r      <= (state_r == S_SWEEP);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Counters, window and payload
  always_ff @(posedge clk) begin
    line_r     <= line_nxt;
    pos_r      <= pos_nxt;
    line_d_r   <= line_r;
    pos_d_r    <= pos_r;
    w_prev_r   <= w_cur_r;
    w_cur_r    <= src_data;
    res_cell_r <= res_cell_nxt;
    res_bad_r  <= res_bad_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_cell_r <= res_cell_r;
      out_bad_r  <= res_bad_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_out    = out_cell_r;
  assign out_bad_request = out_bad_r;

`ifndef SYNTHESIS
  // A new result word is only loaded from the finish state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word appeared outside the finish state");

  // A flagged request never carries cell data
  a_bad_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_cell_r == CELL_EMPTY))
    else $error("bad request word carries a cell value");

  // Sweep writes stay inside the side in use
  a_sweep_in_side: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_wr |-> (int'(center) < int'(side)) && (int'(line_d_r) < int'(side)))
    else $error("sweep write outside the grid");

  // A good read goes through the read wait state
  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_req_type == REQ_READ) && !bad_coord) |=> (state_r == S_RDW))
    else $error("read request skipped the read wait");
`endif

endmodule
`default_nettype wire
